[rtl/core/hsv2rgb_pkg.sv]
// hsv2rgb_pkg: shared types, constants and helpers of the hsv to rgb converter
// no dependencies; used by every module of the block
package hsv2rgb_pkg;

    // field widths
    localparam int HUE_W   = 13;
    localparam int CHAN_W  = 8;
    localparam int SEC_W   = 3;
    localparam int FRAC_W  = 10;
    localparam int SPAN_W  = 18;
    localparam int NUM_W   = 26;
    localparam int SCALE_W = 20;
    localparam int RECIP_W = 21;

    // hue geometry, 1/16 degree units
    localparam logic [HUE_W-1:0] HUE_FULL    = 13'd5760;
    localparam logic [FRAC_W-1:0] HUE_SECTOR = 10'd960;
    localparam int NUM_SECTORS               = 6;

    // term denominator 255 * 960, split into 2^6 * 3825
    localparam logic [SPAN_W-1:0] TERM_DEN = 18'd244800;
    localparam int DEN_SHIFT               = 6;
    // ceil(2^32 / 3825), exact for every 20-bit dividend
    localparam logic [RECIP_W-1:0] RECIP   = 21'd1122868;
    localparam int RECIP_SHIFT             = 32;

    // sector codes
    localparam logic [SEC_W-1:0] SECT_R2Y = 3'd0;
    localparam logic [SEC_W-1:0] SECT_Y2G = 3'd1;
    localparam logic [SEC_W-1:0] SECT_G2C = 3'd2;
    localparam logic [SEC_W-1:0] SECT_C2B = 3'd3;
    localparam logic [SEC_W-1:0] SECT_B2M = 3'd4;
    localparam logic [SEC_W-1:0] SECT_M2R = 3'd5;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [CHAN_W-1:0] saturation;
        logic [CHAN_W-1:0] brightness;
    } t_hsv;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb;

    // per-stage load enables of the term pipeline
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } t_adv;

    // start of a sector on the hue axis
    function automatic logic [HUE_W-1:0] sector_base(input logic [SEC_W-1:0] sec);
        logic [HUE_W-1:0] base;
        case (sec)
            SECT_R2Y: base = 13'd0;
            SECT_Y2G: base = 13'd960;
            SECT_G2C: base = 13'd1920;
            SECT_C2B: base = 13'd2880;
            SECT_B2M: base = 13'd3840;
            SECT_M2R: base = 13'd4800;
            default:  base = 13'd0;
        endcase
        return base;
    endfunction

endpackage

[rtl/core/hsv2rgb_sector.sv]
// hsv2rgb_sector: first stage, folds the hue and splits it into sector and fraction
// depends on hsv2rgb_pkg
module hsv2rgb_sector (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  hsv2rgb_pkg::t_hsv                 i_data,
    output logic [hsv2rgb_pkg::SEC_W-1:0]     o_sector,
    output logic [hsv2rgb_pkg::FRAC_W-1:0]    o_frac,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]    o_sat,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]    o_val
);

    logic [hsv2rgb_pkg::HUE_W-1:0]  hue_fold;
    logic [hsv2rgb_pkg::SEC_W-1:0]  sec;
    logic [hsv2rgb_pkg::HUE_W-1:0]  rem;

    logic [hsv2rgb_pkg::SEC_W-1:0]  r_sector;
    logic [hsv2rgb_pkg::FRAC_W-1:0] r_frac;
    logic [hsv2rgb_pkg::CHAN_W-1:0] r_sat;
    logic [hsv2rgb_pkg::CHAN_W-1:0] r_val;

    // full circle and above wrap back by one turn
    always_comb begin
        if (i_data.hue >= hsv2rgb_pkg::HUE_FULL) begin
            hue_fold = i_data.hue - hsv2rgb_pkg::HUE_FULL;
        end else begin
            hue_fold = i_data.hue;
        end
    end

    // sector by independent threshold compares, fraction from the sector base
    always_comb begin
        sec = hsv2rgb_pkg::SECT_R2Y;
        for (int k = 1; k < hsv2rgb_pkg::NUM_SECTORS; k++) begin
            if (hue_fold >= hsv2rgb_pkg::sector_base(hsv2rgb_pkg::SEC_W'(k))) begin
                sec = hsv2rgb_pkg::SEC_W'(k);
            end
        end
        rem = hue_fold - hsv2rgb_pkg::sector_base(sec);
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sector <= sec;
            r_frac   <= rem[hsv2rgb_pkg::FRAC_W-1:0];
            r_sat    <= i_data.saturation;
            r_val    <= i_data.brightness;
        end
    end

    assign o_sector = r_sector;
    assign o_frac   = r_frac;
    assign o_sat    = r_sat;
    assign o_val    = r_val;

endmodule

[rtl/core/hsv2rgb_term.sv]
// hsv2rgb_term: three-stage pipeline for one term v*(1 - s*g/(255*960)), truncated
// depends on hsv2rgb_pkg
module hsv2rgb_term (
    input  logic                              i_clk,
    input  hsv2rgb_pkg::t_adv                 i_adv,
    input  logic [hsv2rgb_pkg::CHAN_W-1:0]    i_sat,
    input  logic [hsv2rgb_pkg::CHAN_W-1:0]    i_val,
    input  logic [hsv2rgb_pkg::FRAC_W-1:0]    i_g,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]    o_term
);

    logic [hsv2rgb_pkg::SPAN_W-1:0]             sg;
    logic [hsv2rgb_pkg::NUM_W-1:0]              num;
    logic [hsv2rgb_pkg::SCALE_W+hsv2rgb_pkg::RECIP_W-1:0] quot_full;

    logic [hsv2rgb_pkg::SPAN_W-1:0]  r_span;
    logic [hsv2rgb_pkg::CHAN_W-1:0]  r_val;
    logic [hsv2rgb_pkg::SCALE_W-1:0] r_scaled;
    logic [hsv2rgb_pkg::CHAN_W-1:0]  r_term;

    // stage 2: 255*960 - s*g, never negative
    assign sg = {{(hsv2rgb_pkg::SPAN_W-hsv2rgb_pkg::CHAN_W){1'b0}}, i_sat}
              * {{(hsv2rgb_pkg::SPAN_W-hsv2rgb_pkg::FRAC_W){1'b0}}, i_g};

    always_ff @(posedge i_clk) begin
        if (i_adv.s2) begin
            r_span <= hsv2rgb_pkg::TERM_DEN - sg;
            r_val  <= i_val;
        end
    end

    // stage 3: numerator v * span, shifted right by 6 for the 2^6 factor of the denominator
    assign num = {{(hsv2rgb_pkg::NUM_W-hsv2rgb_pkg::CHAN_W){1'b0}}, r_val}
               * {{(hsv2rgb_pkg::NUM_W-hsv2rgb_pkg::SPAN_W){1'b0}}, r_span};

    always_ff @(posedge i_clk) begin
        if (i_adv.s3) begin
            r_scaled <= num[hsv2rgb_pkg::NUM_W-1:hsv2rgb_pkg::DEN_SHIFT];
        end
    end

    // stage 4: divide by 3825 through the reciprocal, exact floor
    assign quot_full = {{hsv2rgb_pkg::RECIP_W{1'b0}}, r_scaled}
                     * {{hsv2rgb_pkg::SCALE_W{1'b0}}, hsv2rgb_pkg::RECIP};

    always_ff @(posedge i_clk) begin
        if (i_adv.s4) begin
            r_term <= quot_full[hsv2rgb_pkg::RECIP_SHIFT+hsv2rgb_pkg::CHAN_W-1:
                                hsv2rgb_pkg::RECIP_SHIFT];
        end
    end

    assign o_term = r_term;

endmodule

[rtl/core/hsv_to_rgb_converter_core.sv]
// hsv_to_rgb_converter_core: top level, pipeline control, term units and sector routing
// depends on hsv2rgb_pkg, hsv2rgb_sector, hsv2rgb_term
//
// usage
//   input channel: i_valid / o_ready with i_data (hue, saturation, brightness)
//   output channel: o_valid / i_ready with o_data (red, green, blue)
//   an item moves on a rising edge where valid and ready are both high
// timing
//   five register stages: sector split, s*g, v*span, reciprocal divide, routing
//   one item per cycle sustained while the receiver is ready, set by the three
//   chained multipliers each taking a stage of their own
// stall behavior
//   each stage holds its item while the next one is full and stalled; a stage
//   with no item still takes a new one, so bubbles close up under backpressure
//   o_ready depends on i_ready through the stage valid bits
// reset
//   synchronous active-low reset empties all stages; o_valid is low after it
//   zero saturation needs no special path: all three terms then equal brightness
module hsv_to_rgb_converter_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  hsv2rgb_pkg::t_hsv  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output hsv2rgb_pkg::t_rgb  o_data
);

    logic r_vld1, r_vld2, r_vld3, r_vld4, r_vld5;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    hsv2rgb_pkg::t_adv adv;
    logic ld1, ld5;

    logic [hsv2rgb_pkg::SEC_W-1:0]  sec1;
    logic [hsv2rgb_pkg::FRAC_W-1:0] frac1;
    logic [hsv2rgb_pkg::FRAC_W-1:0] frac1_inv;
    logic [hsv2rgb_pkg::CHAN_W-1:0] sat1;
    logic [hsv2rgb_pkg::CHAN_W-1:0] val1;

    logic [hsv2rgb_pkg::SEC_W-1:0]  r_sec2, r_sec3, r_sec4;
    logic [hsv2rgb_pkg::CHAN_W-1:0] r_val2, r_val3, r_val4;
    logic [hsv2rgb_pkg::CHAN_W-1:0] term_p, term_q, term_t;

    hsv2rgb_pkg::t_rgb n_out;
    hsv2rgb_pkg::t_rgb r_out;

    // a stage takes an item when empty or when its own item moves on
    assign rdy5 = !r_vld5 || i_ready;
    assign rdy4 = !r_vld4 || rdy5;
    assign rdy3 = !r_vld3 || rdy4;
    assign rdy2 = !r_vld2 || rdy3;
    assign rdy1 = !r_vld1 || rdy2;

    assign ld1    = rdy1 && i_valid;
    assign adv.s2 = rdy2 && r_vld1;
    assign adv.s3 = rdy3 && r_vld2;
    assign adv.s4 = rdy4 && r_vld3;
    assign ld5    = rdy5 && r_vld4;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
        end else begin
            if (rdy1) r_vld1 <= i_valid;
            if (rdy2) r_vld2 <= r_vld1;
            if (rdy3) r_vld3 <= r_vld2;
            if (rdy4) r_vld4 <= r_vld3;
            if (rdy5) r_vld5 <= r_vld4;
        end
    end

    // stage 1: sector and fraction
    hsv2rgb_sector u_sector (
        .i_clk    (i_clk),
        .i_en     (ld1),
        .i_data   (i_data),
        .o_sector (sec1),
        .o_frac   (frac1),
        .o_sat    (sat1),
        .o_val    (val1)
    );

    assign frac1_inv = hsv2rgb_pkg::HUE_SECTOR - frac1;

    // stages 2 to 4: p uses g = 960, q uses the fraction, t its complement
    hsv2rgb_term u_term_p (
        .i_clk  (i_clk),
        .i_adv  (adv),
        .i_sat  (sat1),
        .i_val  (val1),
        .i_g    (hsv2rgb_pkg::HUE_SECTOR),
        .o_term (term_p)
    );

    hsv2rgb_term u_term_q (
        .i_clk  (i_clk),
        .i_adv  (adv),
        .i_sat  (sat1),
        .i_val  (val1),
        .i_g    (frac1),
        .o_term (term_q)
    );

    hsv2rgb_term u_term_t (
        .i_clk  (i_clk),
        .i_adv  (adv),
        .i_sat  (sat1),
        .i_val  (val1),
        .i_g    (frac1_inv),
        .o_term (term_t)
    );

    // sector and brightness follow the terms
    always_ff @(posedge i_clk) begin
        if (adv.s2) begin
            r_sec2 <= sec1;
            r_val2 <= val1;
        end
        if (adv.s3) begin
            r_sec3 <= r_sec2;
            r_val3 <= r_val2;
        end
        if (adv.s4) begin
            r_sec4 <= r_sec3;
            r_val4 <= r_val3;
        end
    end

    // stage 5: route terms to channels by sector
    always_comb begin
        case (r_sec4)
            hsv2rgb_pkg::SECT_R2Y: n_out = '{red: r_val4, green: term_t, blue: term_p};
            hsv2rgb_pkg::SECT_Y2G: n_out = '{red: term_q, green: r_val4, blue: term_p};
            hsv2rgb_pkg::SECT_G2C: n_out = '{red: term_p, green: r_val4, blue: term_t};
            hsv2rgb_pkg::SECT_C2B: n_out = '{red: term_p, green: term_q, blue: r_val4};
            hsv2rgb_pkg::SECT_B2M: n_out = '{red: term_t, green: term_p, blue: r_val4};
            hsv2rgb_pkg::SECT_M2R: n_out = '{red: r_val4, green: term_p, blue: term_q};
            default:               n_out = '{red: r_val4, green: term_p, blue: term_q};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ld5) begin
            r_out <= n_out;
        end
    end

    assign o_ready = rdy1;
    assign o_valid = r_vld5;
    assign o_data  = r_out;

endmodule

[rtl/core/hsv2rgb_checker.sv]
// hsv2rgb_checker: port-level assertions for hsv_to_rgb_converter_core, bound to the top
// depends on hsv2rgb_pkg and hsv_to_rgb_converter_core
module hsv2rgb_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_ready,
    input  hsv2rgb_pkg::t_hsv  i_data,
    input  logic               o_valid,
    input  logic               i_ready,
    input  hsv2rgb_pkg::t_rgb  o_data
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result item dropped while stalled");

    // a stalled result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_data))
        else $error("result item changed while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result item offered right after reset");

    // a ready receiver never blocks the input
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> o_ready)
        else $error("input stalled with receiver ready");

    // an accepted item reaches the output through all stages when the receiver stays ready
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) ##1 i_ready ##1 i_ready ##1 i_ready ##1 i_ready
        |=> o_valid)
        else $error("item missing at the output after pipeline latency");

endmodule

bind hsv_to_rgb_converter_core hsv2rgb_checker u_hsv2rgb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
